// ===== rtl/hover_integrator_offset_estimator_assert.svh =====
// Assertion macros used by the hover integrator offset estimator back end.
`ifndef HOVER_INTEGRATOR_OFFSET_ESTIMATOR_ASSERT_SVH
`define HOVER_INTEGRATOR_OFFSET_ESTIMATOR_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define HIOE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication.
`define HIOE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HIOE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hioe_pkg.sv =====
// Package: constants, types and helpers of the hover integrator offset estimator.
`timescale 1ns / 1ps
`default_nettype none
package hioe_pkg;

   localparam int SETTLE_TICKS = 40;
   localparam int WINDOW_TICKS = 80;
   localparam int LAST_TICK    = SETTLE_TICKS + WINDOW_TICKS;
   localparam int TICK_W       = $clog2(LAST_TICK + 1);

   localparam int DATA_W  = 16;
   localparam int LIMIT_W = 15;
   localparam int SUM_W   = 24;
   localparam int MAG_W   = SUM_W - 1;

   // Divide by the window as a multiply by a rounded-up reciprocal.
   localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_TICKS);
   localparam int RECIP_W   = MAG_W + 1;
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << DIV_SHIFT) + WINDOW_TICKS - 1) / WINDOW_TICKS;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   localparam logic [LIMIT_W-1:0] POS_ERR_LIMIT_RST  = LIMIT_W'(2048);
   localparam logic [LIMIT_W-1:0] VEL_SET_LIMIT_RST  = LIMIT_W'(819);
   localparam logic [LIMIT_W-1:0] VEL_MEAS_LIMIT_RST = LIMIT_W'(819);
   localparam logic [LIMIT_W-1:0] VEL_ERR_LIMIT_RST  = LIMIT_W'(410);

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POS_ERR_LIMIT,
      CSR_VEL_SET_LIMIT,
      CSR_VEL_MEAS_LIMIT,
      CSR_VEL_ERR_LIMIT
   } csr_index_type;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_REARM  = 1'b1;

   typedef struct packed {
      logic                     func;
      logic                     stable;
      logic signed [DATA_W-1:0] integrator;
   } hioe_item_type;

   typedef struct packed {
      logic          valid;
      hioe_item_type item;
   } hioe_push_type;

   typedef struct packed {
      logic                     ready;
      logic                     have;
      logic signed [SUM_W-1:0]  sum;
      logic signed [DATA_W-1:0] run_min;
      logic signed [DATA_W-1:0] run_max;
      logic signed [DATA_W-1:0] integ;
   } hioe_s1_type;

   typedef struct packed {
      logic                     ready;
      logic                     have;
      logic                     neg;
      logic [PROD_W-1:0]        prod;
      logic [DATA_W-1:0]        spread;
      logic signed [DATA_W-1:0] integ;
   } hioe_s2_type;

   // Magnitude of a 17-bit signed value; callers never pass the most negative code.
   function automatic logic [DATA_W:0] abs17(input logic signed [DATA_W:0] v);
      logic signed [DATA_W:0] n;
      n = -v;
      return v[DATA_W] ? n : v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hioe_if.sv =====
// Interfaces: request and response channels of the offset estimator.
`timescale 1ns / 1ps
`default_nettype none
interface hioe_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] position_error;
   logic signed [15:0] velocity_setpoint;
   logic signed [15:0] velocity_measured;
   logic signed [15:0] integrator;

   modport source (output valid, func, position_error, velocity_setpoint,
                   velocity_measured, integrator, input ready);
   modport sink (input valid, func, position_error, velocity_setpoint,
                 velocity_measured, integrator, output ready);
endinterface

interface hioe_rsp_if;
   logic               valid;
   logic               ready;
   logic               correction_ready;
   logic signed [15:0] correction;
   logic [15:0]        spread;
   logic signed [15:0] adjusted_integrator;
   logic               have_result;

   modport source (output valid, correction_ready, correction, spread,
                   adjusted_integrator, have_result, input ready);
   modport sink (input valid, correction_ready, correction, spread,
                 adjusted_integrator, have_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/hover_integrator_offset_estimator.sv =====
// Top level of the hover integrator offset estimator.
`timescale 1ns / 1ps
`default_nettype none
// Hover integrator offset estimator. Each request item is one control-loop
// tick: func (0 sample, 1 rearm) plus position error, velocity setpoint,
// measured velocity and loop integrator, all signed Q4.12. Every item gives
// exactly one response item, in order. A tick is stable when |position error|,
// |velocity setpoint|, |measured velocity| and |setpoint - measured| are each
// strictly below their limit register. The first stable tick arms sampling;
// after SETTLE_TICKS further stable ticks the integrator is summed and its
// min and max tracked for WINDOW_TICKS ticks; any unstable tick disarms. On
// the last window tick the response carries correction_ready, the average
// (rounded toward zero), the max-minus-min spread and the integrator minus
// the average saturated to 16 bits; done then latches (have_result) until a
// rearm item. Limits are written through csr_we / csr_index / csr_wdata
// (0 position error, 1 setpoint velocity, 2 measured velocity, 3 velocity
// error; 15 bits); the user must write them only while the block is idle,
// which the block itself leaves unchecked. With rsp.ready high, throughput
// is one item per clock: the front end classifies an item as it is accepted
// and drops it in a two-entry queue, and the back end runs a three-register
// pipeline (state update, reciprocal multiply for the divide by the window,
// saturate and response register). On a response stall req.ready falls
// once the queue holds two items. No clearing pass after reset.
module hover_integrator_offset_estimator import hioe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata,
   hioe_req_if.sink               req,
   hioe_rsp_if.source             rsp
);

   hioe_push_type push;
   hioe_push_type head;
   logic          full;
   logic          pop;

   // Limit registers and stability check live in the front end.
   hioe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .full      (full),
      .push      (push)
   );

   // Hold classified items while the back end is stalled.
   hioe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   // Advance the estimator state and build the response.
   hioe_back u_back (
      .clock (clock),
      .reset (reset),
      .q     (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire

// ===== rtl/hioe_front.sv =====
// Front end: limit registers, item intake and stability classification.
`timescale 1ns / 1ps
`default_nettype none
module hioe_front import hioe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata,
   hioe_req_if.sink               req,
   input  logic                   full,
   output hioe_push_type          push
);

   logic [LIMIT_W-1:0] pos_lim_ff, pos_lim_in;
   logic [LIMIT_W-1:0] vset_lim_ff, vset_lim_in;
   logic [LIMIT_W-1:0] vmeas_lim_ff, vmeas_lim_in;
   logic [LIMIT_W-1:0] verr_lim_ff, verr_lim_in;
   logic               stable;

   always_comb begin
      pos_lim_in   = pos_lim_ff;
      vset_lim_in  = vset_lim_ff;
      vmeas_lim_in = vmeas_lim_ff;
      verr_lim_in  = verr_lim_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POS_ERR_LIMIT:  pos_lim_in   = csr_wdata;
            CSR_VEL_SET_LIMIT:  vset_lim_in  = csr_wdata;
            CSR_VEL_MEAS_LIMIT: vmeas_lim_in = csr_wdata;
            CSR_VEL_ERR_LIMIT:  verr_lim_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_lim_ff   <= POS_ERR_LIMIT_RST;
         vset_lim_ff  <= VEL_SET_LIMIT_RST;
         vmeas_lim_ff <= VEL_MEAS_LIMIT_RST;
         verr_lim_ff  <= VEL_ERR_LIMIT_RST;
      end else begin
         pos_lim_ff   <= pos_lim_in;
         vset_lim_ff  <= vset_lim_in;
         vmeas_lim_ff <= vmeas_lim_in;
         verr_lim_ff  <= verr_lim_in;
      end
   end

   // All four magnitudes strictly below their limits.
   always_comb begin
      logic signed [DATA_W:0] vdiff;
      vdiff  = {req.velocity_setpoint[DATA_W-1], req.velocity_setpoint}
             - {req.velocity_measured[DATA_W-1], req.velocity_measured};
      stable = (abs17({req.position_error[DATA_W-1], req.position_error})
                  < {2'b00, pos_lim_ff})
            && (abs17({req.velocity_setpoint[DATA_W-1], req.velocity_setpoint})
                  < {2'b00, vset_lim_ff})
            && (abs17({req.velocity_measured[DATA_W-1], req.velocity_measured})
                  < {2'b00, vmeas_lim_ff})
            && (abs17(vdiff) < {2'b00, verr_lim_ff});
   end

   assign req.ready            = !full;
   assign push.valid           = req.valid && !full;
   assign push.item.func       = req.func;
   assign push.item.stable     = stable;
   assign push.item.integrator = req.integrator;

endmodule
`default_nettype wire

// ===== rtl/hioe_queue.sv =====
// Two-entry queue between the front end and the estimator back end.
`timescale 1ns / 1ps
`default_nettype none
module hioe_queue import hioe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  hioe_push_type push,
   input  logic          pop,
   output hioe_push_type head,
   output logic          full
);

   hioe_item_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign full       = (cnt_ff == 2'd2);

endmodule
`default_nettype wire

// ===== rtl/hioe_back.sv =====
// Back end: estimator state update, window average and response register.
`timescale 1ns / 1ps
`default_nettype none
`include "hover_integrator_offset_estimator_assert.svh"
module hioe_back import hioe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  hioe_push_type q,
   output logic          pop,
   hioe_rsp_if.source    rsp
);

   logic                     adv;
   logic                     armed_ff, armed_in;
   logic                     done_ff, done_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic signed [DATA_W-1:0] max_ff, max_in;

   hioe_s1_type s1_ff, s1_in;
   logic        s1_valid_ff;
   hioe_s2_type s2_ff, s2_in;
   logic        s2_valid_ff;

   logic                     rsp_valid_ff;
   logic                     corr_ready_ff;
   logic signed [DATA_W-1:0] correction_ff, correction_in;
   logic [DATA_W-1:0]        spread_ff;
   logic signed [DATA_W-1:0] adj_ff, adj_in;
   logic                     have_ff;

   // The whole back end advances together when the response slot frees.
   assign adv = !rsp_valid_ff || rsp.ready;
   assign pop = adv && q.valid;

   always_comb begin
      logic [TICK_W-1:0]        tick_nx;
      logic signed [SUM_W-1:0]  sum_nx;
      logic signed [DATA_W-1:0] min_nx;
      logic signed [DATA_W-1:0] max_nx;
      tick_nx = tick_ff + 1'b1;
      sum_nx  = sum_ff + SUM_W'(q.item.integrator);
      min_nx  = (q.item.integrator < min_ff) ? q.item.integrator : min_ff;
      max_nx  = (q.item.integrator > max_ff) ? q.item.integrator : max_ff;
      armed_in = armed_ff;
      done_in  = done_ff;
      tick_in  = tick_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      s1_in.ready = 1'b0;
      s1_in.have  = done_ff;
      s1_in.integ = q.item.integrator;
      if (q.item.func == FUNC_REARM) begin
         armed_in   = 1'b0;
         done_in    = 1'b0;
         tick_in    = '0;
         sum_in     = '0;
         min_in     = '0;
         max_in     = '0;
         s1_in.have = 1'b0;
      end else if (!done_ff) begin
         if (!q.item.stable) begin
            armed_in = 1'b0;
         end else if (!armed_ff) begin
            armed_in = 1'b1;
            tick_in  = '0;
            sum_in   = '0;
            min_in   = '0;
            max_in   = '0;
         end else begin
            tick_in = tick_nx;
            if (tick_nx > TICK_W'(SETTLE_TICKS)) begin
               sum_in = sum_nx;
               min_in = min_nx;
               max_in = max_nx;
            end
            if (tick_nx >= TICK_W'(LAST_TICK)) begin
               armed_in    = 1'b0;
               done_in     = 1'b1;
               s1_in.ready = 1'b1;
               s1_in.have  = 1'b1;
            end
         end
      end
      s1_in.sum     = sum_in;
      s1_in.run_min = min_in;
      s1_in.run_max = max_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         done_ff  <= 1'b0;
         tick_ff  <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else if (pop) begin
         armed_ff <= armed_in;
         done_ff  <= done_in;
         tick_ff  <= tick_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   // Magnitude times reciprocal; the shift happens in the next stage.
   always_comb begin
      logic signed [SUM_W-1:0] nsum;
      logic [MAG_W-1:0]        mag;
      nsum        = -s1_ff.sum;
      mag         = s1_ff.sum[SUM_W-1] ? nsum[MAG_W-1:0] : s1_ff.sum[MAG_W-1:0];
      s2_in.ready = s1_ff.ready;
      s2_in.have  = s1_ff.have;
      s2_in.neg   = s1_ff.sum[SUM_W-1];
      s2_in.prod  = PROD_W'(mag) * PROD_W'(RECIP_V);
      s2_in.spread = DATA_W'(s1_ff.run_max - s1_ff.run_min);
      s2_in.integ = s1_ff.integ;
   end

   // Quotient toward zero, then saturated integrator minus correction.
   always_comb begin
      logic [DATA_W:0]          quo;
      logic signed [DATA_W:0]   corr;
      logic signed [DATA_W+1:0] diff;
      quo  = (DATA_W + 1)'(s2_ff.prod >> DIV_SHIFT);
      corr = s2_ff.neg ? -signed'(quo) : signed'(quo);
      diff = {{2{s2_ff.integ[DATA_W-1]}}, s2_ff.integ} - {corr[DATA_W], corr};
      correction_in = s2_ff.ready ? corr[DATA_W-1:0] : '0;
      if (!s2_ff.ready) begin
         adj_in = s2_ff.integ;
      end else if (diff > 18'sd32767) begin
         adj_in = 16'sh7FFF;
      end else if (diff < -18'sd32768) begin
         adj_in = 16'sh8000;
      end else begin
         adj_in = diff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= q.valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         corr_ready_ff <= s2_ff.ready;
         correction_ff <= correction_in;
         spread_ff     <= s2_ff.ready ? s2_ff.spread : '0;
         adj_ff        <= adj_in;
         have_ff       <= s2_ff.have;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.correction_ready    = corr_ready_ff;
   assign rsp.correction          = correction_ff;
   assign rsp.spread              = spread_ff;
   assign rsp.adjusted_integrator = adj_ff;
   assign rsp.have_result         = have_ff;

   `HIOE_ASSERT_ALWAYS(a_tick_bound, tick_ff <= TICK_W'(LAST_TICK), "tick count past window end")
   `HIOE_ASSERT_IMPLY(a_done_disarmed, done_ff, !armed_ff, "armed while done is latched")
   `HIOE_ASSERT_IMPLY(a_ready_has, s1_valid_ff && s1_ff.ready, s1_ff.have, "ready without done")
   `HIOE_ASSERT_NEXT(a_rearm_clears, pop && q.item.func == FUNC_REARM, !armed_ff && !done_ff && tick_ff == '0, "rearm left state")

endmodule
`default_nettype wire

// ===== sim/tb_hover_integrator_offset_estimator.sv =====
// Testbench for the hover integrator offset estimator: directed and random ticks against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_hover_integrator_offset_estimator;
   import hioe_pkg::*;

   // One control-loop tick as it goes onto the request channel.
   typedef struct {
      logic                     func;
      logic signed [DATA_W-1:0] perr;
      logic signed [DATA_W-1:0] vset;
      logic signed [DATA_W-1:0] vmeas;
      logic signed [DATA_W-1:0] integ;
   } tick_type;

   // What the block should report for one tick.
   typedef struct {
      logic              ready;
      logic [DATA_W-1:0] correction;
      logic [DATA_W-1:0] spread;
      logic [DATA_W-1:0] adjusted;
      logic              have;
   } report_type;

   // How the integrator moves across one window.
   typedef enum {
      SPREAD_ANY,
      PULL_LOW,
      PULL_HIGH,
      NEAR_ZERO
   } integ_style_type;

   // Which limit an upset tick breaks.
   typedef enum {
      UPSET_PERR_MIN,
      UPSET_VSET_MIN,
      UPSET_VMEAS_MIN,
      UPSET_PERR_EDGE,
      UPSET_VERR_EDGE
   } upset_kind_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [LIMIT_W-1:0] csr_wdata;

   hioe_req_if req_bus ();
   hioe_rsp_if rsp_bus ();

   hover_integrator_offset_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus)
   );

   // Ticks waiting to be sent, and reports the block still owes.
   tick_type   tick_backlog [$];
   report_type pending_reports [$];

   int  ticks_queued   = 0;
   int  ticks_taken    = 0;
   int  rearms_taken   = 0;
   int  windows_seen   = 0;
   int  mismatches     = 0;
   bit  calm           = 1'b0;

   // Predictor copy of the limit registers and the estimator state.
   logic [LIMIT_W-1:0] limit_reg [4];
   bit est_armed;
   bit est_done;
   int est_count;
   int est_sum;
   int est_min;
   int est_max;

   tick_type   on_bus;
   int         send_gap;
   int         recv_stall;
   report_type want;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int mag(input int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void clear_estimate();
      est_armed = 1'b0;
      est_done  = 1'b0;
      est_count = 0;
      est_sum   = 0;
      est_min   = 0;
      est_max   = 0;
   endfunction

   // Advance the estimator by one tick and return the report it owes.
   function automatic report_type estimate_tick(input tick_type t);
      report_type r;
      int         corr;
      int         d;
      bit         steady;
      r.ready      = 1'b0;
      r.correction = '0;
      r.spread     = '0;
      r.adjusted   = t.integ;
      if (t.func == FUNC_REARM) begin
         clear_estimate();
         rearms_taken++;
      end else if (!est_done) begin
         steady = mag(int'(t.perr)) < int'(limit_reg[CSR_POS_ERR_LIMIT]) &&
                  mag(int'(t.vset)) < int'(limit_reg[CSR_VEL_SET_LIMIT]) &&
                  mag(int'(t.vmeas)) < int'(limit_reg[CSR_VEL_MEAS_LIMIT]) &&
                  mag(int'(t.vset) - int'(t.vmeas)) < int'(limit_reg[CSR_VEL_ERR_LIMIT]);
         if (!steady) begin
            est_armed = 1'b0;
         end else if (!est_armed) begin
            // first stable tick only arms and clears the accumulators
            est_armed = 1'b1;
            est_count = 0;
            est_sum   = 0;
            est_min   = 0;
            est_max   = 0;
         end else begin
            est_count++;
            if (est_count > SETTLE_TICKS) begin
               est_sum += int'(t.integ);
               if (int'(t.integ) < est_min) est_min = int'(t.integ);
               if (int'(t.integ) > est_max) est_max = int'(t.integ);
            end
            if (est_count >= SETTLE_TICKS + WINDOW_TICKS) begin
               // SV division truncates toward zero, as the block must
               corr = est_sum / WINDOW_TICKS;
               d = int'(t.integ) - corr;
               if (d > 32767) d = 32767;
               if (d < -32768) d = -32768;
               r.ready      = 1'b1;
               r.correction = DATA_W'(corr);
               r.adjusted   = DATA_W'(d);
               r.spread     = DATA_W'(est_max - est_min);
               est_armed    = 1'b0;
               est_done     = 1'b1;
            end
         end
      end
      r.have = est_done;
      return r;
   endfunction

   function automatic void push_tick(input tick_type t);
      tick_backlog.push_back(t);
      ticks_queued++;
   endfunction

   function automatic tick_type tick_of(input logic func, input int perr, input int vset,
                                        input int vmeas, input int integ);
      tick_type t;
      t.func  = func;
      t.perr  = DATA_W'(perr);
      t.vset  = DATA_W'(vset);
      t.vmeas = DATA_W'(vmeas);
      t.integ = DATA_W'(integ);
      return t;
   endfunction

   // Random value in [-m, m], with the endpoints -m and m favored.
   function automatic int pick_span(input int m);
      if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? m : -m;
      return int'($urandom_range(2 * m)) - m;
   endfunction

   // Build a tick that passes all four limits; every limit must be at least 1.
   function automatic tick_type steady_tick(input logic signed [DATA_W-1:0] integ);
      tick_type t;
      int       vs;
      int       lo;
      int       hi;
      int       span_m;
      int       span_e;
      span_m  = int'(limit_reg[CSR_VEL_MEAS_LIMIT]) - 1;
      span_e  = int'(limit_reg[CSR_VEL_ERR_LIMIT]) - 1;
      t.func  = FUNC_SAMPLE;
      t.integ = integ;
      t.perr  = DATA_W'(pick_span(int'(limit_reg[CSR_POS_ERR_LIMIT]) - 1));
      vs = pick_span(int'(limit_reg[CSR_VEL_SET_LIMIT]) - 1);
      lo = (vs - span_e > -span_m) ? vs - span_e : -span_m;
      hi = (vs + span_e < span_m) ? vs + span_e : span_m;
      if (lo > hi) begin
         // no measured velocity fits next to this setpoint; fall back to rest
         vs = 0;
         lo = 0;
         hi = 0;
      end
      t.vset = DATA_W'(vs);
      if ($urandom_range(0, 3) == 0)
         t.vmeas = DATA_W'(($urandom_range(0, 1) != 0) ? hi : lo);
      else
         t.vmeas = DATA_W'(lo + int'($urandom_range(hi - lo)));
      return t;
   endfunction

   // Take a stable tick and break at least one limit, at the most negative code or at the edge.
   function automatic tick_type upset_tick(input logic signed [DATA_W-1:0] integ);
      tick_type       t;
      upset_kind_type kind;
      int             sign;
      t    = steady_tick(integ);
      kind = upset_kind_type'($urandom_range(0, 4));
      sign = ($urandom_range(0, 1) != 0) ? 1 : -1;
      case (kind)
         UPSET_PERR_MIN:  t.perr  = 16'sh8000;
         UPSET_VSET_MIN:  t.vset  = 16'sh8000;
         UPSET_VMEAS_MIN: t.vmeas = 16'sh8000;
         UPSET_PERR_EDGE: t.perr  = DATA_W'(sign * int'(limit_reg[CSR_POS_ERR_LIMIT]));
         default: begin
            t.vset  = '0;
            t.vmeas = DATA_W'(sign * int'(limit_reg[CSR_VEL_ERR_LIMIT]));
         end
      endcase
      return t;
   endfunction

   function automatic tick_type noise_tick(input logic func);
      return tick_of(func, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
   endfunction

   // Queue one window's worth of stable ticks, usually behind a rearm, sometimes broken.
   function automatic void queue_episode();
      integ_style_type style;
      bit              broken;
      logic signed [DATA_W-1:0] v;
      style  = integ_style_type'($urandom_range(0, 3));
      broken = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0) push_tick(noise_tick(FUNC_REARM));
      for (int k = 0; k <= SETTLE_TICKS + WINDOW_TICKS; k++) begin
         // the skewed styles jump to the far rail on the closing tick to force saturation
         case (style)
            PULL_LOW:
               v = (k == SETTLE_TICKS + WINDOW_TICKS) ? 16'sh7FFF :
                   DATA_W'(-32768 + int'($urandom_range(0, 255)));
            PULL_HIGH:
               v = (k == SETTLE_TICKS + WINDOW_TICKS) ? 16'sh8000 :
                   DATA_W'(32767 - int'($urandom_range(0, 255)));
            NEAR_ZERO: v = DATA_W'(int'($urandom_range(0, 63)) - 32);
            default:   v = DATA_W'($urandom);
         endcase
         push_tick(steady_tick(v));
         if (broken && $urandom_range(0, 59) == 0) push_tick(upset_tick(v));
      end
      // keep ticking while done is latched
      repeat ($urandom_range(1, 4)) push_tick(steady_tick(DATA_W'($urandom)));
      if ($urandom_range(0, 2) == 0) push_tick(noise_tick(FUNC_SAMPLE));
   endfunction

   task automatic write_limit(input csr_index_type which, input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_we           <= 1'b1;
      csr_index        <= which;
      csr_wdata        <= value;
      limit_reg[which]  = value;
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] pe, input logic [LIMIT_W-1:0] vs,
                             input logic [LIMIT_W-1:0] vm, input logic [LIMIT_W-1:0] ve);
      write_limit(CSR_POS_ERR_LIMIT, pe);
      write_limit(CSR_VEL_SET_LIMIT, vs);
      write_limit(CSR_VEL_MEAS_LIMIT, vm);
      write_limit(CSR_VEL_ERR_LIMIT, ve);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold the sender until every tick is taken and every report is back, then let the pipe empty.
   task automatic drain();
      do @(posedge clock);
      while (ticks_taken != ticks_queued || pending_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic void compare_field(input string what, input logic [DATA_W-1:0] expd,
                                         input logic [DATA_W-1:0] got);
      if (got !== expd) begin
         mismatches++;
         $display("%0t: %s expected %h, got %h", $time, what, expd, got);
      end
   endfunction

   // Request driver: present the next item once the current one is taken, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_reports.push_back(estimate_tick(on_bus));
            ticks_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (tick_backlog.size() > 0) begin
               on_bus = tick_backlog.pop_front();
               req_bus.func              <= on_bus.func;
               req_bus.position_error    <= on_bus.perr;
               req_bus.velocity_setpoint <= on_bus.vset;
               req_bus.velocity_measured <= on_bus.vmeas;
               req_bus.integrator        <= on_bus.integ;
               req_bus.valid             <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each item against the oldest report owed, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: response item with no report owed", $time);
            end else begin
               want = pending_reports.pop_front();
               compare_field("correction_ready", DATA_W'(want.ready),
                             DATA_W'(rsp_bus.correction_ready));
               compare_field("correction", want.correction, rsp_bus.correction);
               compare_field("spread", want.spread, rsp_bus.spread);
               compare_field("adjusted_integrator", want.adjusted, rsp_bus.adjusted_integrator);
               compare_field("have_result", DATA_W'(want.have), DATA_W'(rsp_bus.have_result));
               if (want.ready) windows_seen++;
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 3) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      // Drive every input to a known value before the first edge.
      reset                     = 1'b1;
      csr_we                    = 1'b0;
      csr_index                 = CSR_POS_ERR_LIMIT;
      csr_wdata                 = '0;
      req_bus.valid             = 1'b0;
      req_bus.func              = FUNC_SAMPLE;
      req_bus.position_error    = '0;
      req_bus.velocity_setpoint = '0;
      req_bus.velocity_measured = '0;
      req_bus.integrator        = '0;
      rsp_bus.ready             = 1'b0;
      limit_reg[CSR_POS_ERR_LIMIT]  = POS_ERR_LIMIT_RST;
      limit_reg[CSR_VEL_SET_LIMIT]  = VEL_SET_LIMIT_RST;
      limit_reg[CSR_VEL_MEAS_LIMIT] = VEL_MEAS_LIMIT_RST;
      limit_reg[CSR_VEL_ERR_LIMIT]  = VEL_ERR_LIMIT_RST;
      clear_estimate();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset limits: most negative codes, values on and just
      // inside each limit, arm, disarm, rearm with all bits set.
      push_tick(noise_tick(FUNC_REARM));
      push_tick(tick_of(FUNC_SAMPLE, -32768, 0, 0, 0));
      push_tick(tick_of(FUNC_SAMPLE, 0, -32768, 0, 0));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, -32768, 0));
      push_tick(tick_of(FUNC_SAMPLE, 2048, 0, 0, 0));
      push_tick(tick_of(FUNC_SAMPLE, 2047, 0, 0, 100));
      push_tick(tick_of(FUNC_SAMPLE, -2047, 409, 0, 32767));
      push_tick(tick_of(FUNC_SAMPLE, 0, 818, 409, -32768));
      push_tick(tick_of(FUNC_SAMPLE, 0, -818, -818, -1));
      push_tick(tick_of(FUNC_SAMPLE, 0, 410, 0, 5));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, 0, 7));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, 819, 0));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, 0, 0));
      push_tick(tick_of(FUNC_SAMPLE, 0, -819, -500, 0));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, -409, 32767));
      push_tick(tick_of(FUNC_SAMPLE, 0, 0, 0, 32767));
      push_tick(tick_of(FUNC_REARM, -1, -1, -1, -1));
      push_tick(tick_of(FUNC_SAMPLE, 32767, 32767, 32767, 32767));
      push_tick(tick_of(FUNC_SAMPLE, 1, -1, 1, -32768));
      push_tick(tick_of(FUNC_SAMPLE, -1, 1, 1, 12345));
      drain();

      // Widest limits: random noise is mostly stable, then full windows.
      set_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      repeat (40) push_tick(noise_tick(FUNC_SAMPLE));
      repeat (3) queue_episode();
      drain();

      // Zero limits: nothing can be stable.
      set_limits('0, '0, '0, '0);
      repeat (10) push_tick(tick_of(FUNC_SAMPLE, 0, 0, 0, int'($urandom)));
      repeat (15) push_tick(noise_tick(FUNC_SAMPLE));
      repeat (5) push_tick(noise_tick(FUNC_REARM));
      drain();

      // Random limits of any size.
      set_limits(LIMIT_W'($urandom_range(1, 32767)), LIMIT_W'($urandom_range(1, 32767)),
                 LIMIT_W'($urandom_range(1, 32767)), LIMIT_W'($urandom_range(1, 32767)));
      repeat (20) push_tick(noise_tick(FUNC_SAMPLE));
      repeat (3) queue_episode();
      drain();

      // Narrowest nonzero limits: only zero motion counts as stable.
      set_limits(LIMIT_W'(1), LIMIT_W'(1), LIMIT_W'(1), LIMIT_W'(1));
      repeat (2) queue_episode();
      drain();

      // Back to the reset limits with both sides running flat out.
      set_limits(POS_ERR_LIMIT_RST, VEL_SET_LIMIT_RST, VEL_MEAS_LIMIT_RST, VEL_ERR_LIMIT_RST);
      calm = 1'b1;
      repeat (4) queue_episode();
      drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d ticks, %0d of them rearms, across six limit settings;",
               ticks_taken, rearms_taken);
      $display("%0d estimation windows closed with a correction.", windows_seen);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/hioe_pkg.sv
rtl/hioe_if.sv
rtl/hioe_front.sv
rtl/hioe_queue.sv
rtl/hioe_back.sv
rtl/hover_integrator_offset_estimator.sv
sim/tb_hover_integrator_offset_estimator.sv
